@@ src/bgsr_pkg.sv @@
// ----------------------------------------------------------------------------
// bgsr_pkg: shared types and constants
// Register map, phase codes, queue sizing and the word formats that pass
// between the parts of the glyph span rasteriser.
// ----------------------------------------------------------------------------
package bgsr_pkg;

  localparam int COORD_BITS = 16;
  localparam int ADDR_BITS  = 5;
  localparam int DATA_BITS  = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_DOT_WIDTH  = 3'd0;
  localparam logic [2:0] REG_DOT_HGAP   = 3'd1;
  localparam logic [2:0] REG_DOT_VGAP   = 3'd2;
  localparam logic [2:0] REG_GLYPH_ROWS = 3'd3;
  localparam logic [2:0] REG_CHAR_GAP   = 3'd4;
  localparam logic [2:0] REG_INK_COLOR  = 3'd5;

  // parser phase codes
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_MARGIN = 2'd1;
  localparam logic [1:0] PH_ROWS   = 2'd2;

  // result kinds
  localparam logic KIND_SPAN = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // command queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef struct packed {
    logic [4:0]  dot_width;
    logic [3:0]  dot_hgap;
    logic [3:0]  dot_vgap;
    logic [5:0]  glyph_rows;
    logic [3:0]  char_gap;
    logic [31:0] ink_color;
  } cfg_t;

  // one classified byte: dots to draw (bit k = k-th bit from the MSB),
  // dot index of bit 0 (modulo 256), cell position and an end-of-glyph flag
  typedef struct packed {
    logic [7:0]                   mask;
    logic [7:0]                   d0;
    logic [COORD_BITS-1:0]        cell_x;
    logic [COORD_BITS-1:0]        row_y;
    logic [7:0]                   width;
    logic                         done;
  } cmd_t;

endpackage

@@ src/bgsr_in_if.sv @@
// ----------------------------------------------------------------------------
// bgsr_in_if: glyph byte channel
// Valid/ready channel carrying one glyph byte and the cell origin.
// ----------------------------------------------------------------------------
interface bgsr_in_if;
  import bgsr_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [7:0]                   glyph_byte;
  logic                         first_byte;
  logic signed [COORD_BITS-1:0] origin_x;
  logic signed [COORD_BITS-1:0] origin_y;

  modport source (output valid, glyph_byte, first_byte, origin_x, origin_y,
                  input ready);
  modport sink (input valid, glyph_byte, first_byte, origin_x, origin_y,
                output ready);
endinterface

@@ src/bgsr_out_if.sv @@
// ----------------------------------------------------------------------------
// bgsr_out_if: result channel
// Valid/ready channel carrying one span or one glyph-done word.
// ----------------------------------------------------------------------------
interface bgsr_out_if;
  import bgsr_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [COORD_BITS-1:0] span_left;
  logic signed [COORD_BITS-1:0] span_right;
  logic signed [COORD_BITS-1:0] span_y;
  logic [31:0]                  span_color;
  logic signed [COORD_BITS-1:0] advance_x;
  logic                         last;

  modport source (output valid, kind, span_left, span_right, span_y, span_color,
                  advance_x, last, input ready);
  modport sink (input valid, kind, span_left, span_right, span_y, span_color,
                advance_x, last, output ready);
endinterface

@@ src/bgsr_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// bgsr_cfg_regs: configuration register file
// APB-style slave holding the dot geometry, row count and ink colour.
// ----------------------------------------------------------------------------
module bgsr_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bgsr_pkg::ADDR_BITS-1:0] paddr,
  input  logic [bgsr_pkg::DATA_BITS-1:0] pwdata,
  output logic [bgsr_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready,
  output bgsr_pkg::cfg_t                 cfg
);
  import bgsr_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dot_width  <= 5'd1;
      cfg.dot_hgap   <= 4'd0;
      cfg.dot_vgap   <= 4'd0;
      cfg.glyph_rows <= 6'd8;
      cfg.char_gap   <= 4'd1;
      cfg.ink_color  <= 32'hFFFF_FFFF;
    end else if (wr) begin
      case (idx)
        REG_DOT_WIDTH:  cfg.dot_width  <= pwdata[4:0];
        REG_DOT_HGAP:   cfg.dot_hgap   <= pwdata[3:0];
        REG_DOT_VGAP:   cfg.dot_vgap   <= pwdata[3:0];
        REG_GLYPH_ROWS: cfg.glyph_rows <= pwdata[5:0];
        REG_CHAR_GAP:   cfg.char_gap   <= pwdata[3:0];
        REG_INK_COLOR:  cfg.ink_color  <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_DOT_WIDTH:  prdata = {27'd0, cfg.dot_width};
      REG_DOT_HGAP:   prdata = {28'd0, cfg.dot_hgap};
      REG_DOT_VGAP:   prdata = {28'd0, cfg.dot_vgap};
      REG_GLYPH_ROWS: prdata = {26'd0, cfg.glyph_rows};
      REG_CHAR_GAP:   prdata = {28'd0, cfg.char_gap};
      REG_INK_COLOR:  prdata = cfg.ink_color;
      default:        prdata = '0;
    endcase
  end
endmodule

@@ src/bgsr_front.sv @@
// ----------------------------------------------------------------------------
// bgsr_front: glyph byte parser
// Tracks header, margin and row position, and turns each row byte into a
// command holding the dots to draw and whether the glyph ends here.
// ----------------------------------------------------------------------------
module bgsr_front (
  input  logic           clk,
  input  logic           rst,
  input  bgsr_pkg::cfg_t cfg,
  bgsr_in_if.sink        glyph,
  input  logic           q_full,
  output logic           push,
  output bgsr_pkg::cmd_t push_cmd
);
  import bgsr_pkg::*;

  logic [1:0]            phase, phase_next;
  logic [7:0]            glyph_width, glyph_width_next;
  logic [7:0]            left_skip, left_skip_next;
  logic [COORD_BITS-1:0] cell_x, cell_x_next;
  logic [COORD_BITS-1:0] row_y, row_y_next;
  logic [6:0]            rows_done, rows_done_next;
  logic [8:0]            bit_in_row, bit_in_row_next;

  logic       acc;
  logic [8:0] used;
  logic [9:0] row_len;
  logic [9:0] bit_sum;
  logic [6:0] rows_inc;
  logic [8:0] margin_used;
  logic [7:0] mask;
  logic [7:0] cmd_mask;
  logic [9:0] pos [8];
  logic       done;

  assign glyph.ready = !q_full;
  assign acc         = glyph.valid && glyph.ready;

  assign used        = {1'b0, left_skip} + {1'b0, glyph_width};
  assign row_len     = ({1'b0, used} + 10'd7) & ~10'd7;
  assign bit_sum     = {1'b0, bit_in_row} + 10'd8;
  assign rows_inc    = rows_done + 7'd1;
  assign margin_used = {1'b0, glyph.glyph_byte} + {1'b0, glyph_width};

  // dots of this byte that fall inside the row's width
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pos[k]  = {1'b0, bit_in_row} + 10'(k);
      mask[k] = (pos[k] >= {2'b0, left_skip}) && (pos[k] < {1'b0, used}) &&
                glyph.glyph_byte[7-k];
    end
  end

  // parser state update
  always_comb begin
    phase_next       = phase;
    glyph_width_next = glyph_width;
    left_skip_next   = left_skip;
    cell_x_next      = cell_x;
    row_y_next       = row_y;
    rows_done_next   = rows_done;
    bit_in_row_next  = bit_in_row;
    done             = 1'b0;
    push             = 1'b0;
    cmd_mask         = '0;
    if (acc) begin
      if (glyph.first_byte) begin
        glyph_width_next = glyph.glyph_byte;
        cell_x_next      = glyph.origin_x;
        row_y_next       = glyph.origin_y;
        rows_done_next   = '0;
        bit_in_row_next  = '0;
        phase_next       = PH_MARGIN;
      end else begin
        case (phase)
          PH_MARGIN: begin
            left_skip_next  = glyph.glyph_byte;
            bit_in_row_next = '0;
            rows_done_next  = '0;
            phase_next      = PH_ROWS;
            if (cfg.glyph_rows == '0 || margin_used == '0) begin
              done       = 1'b1;
              phase_next = PH_HEADER;
            end
          end
          PH_ROWS: begin
            if (rows_done >= {1'b0, cfg.glyph_rows} || used == '0) begin
              done       = 1'b1;
              phase_next = PH_HEADER;
            end else begin
              cmd_mask = mask;
              if (bit_sum >= row_len) begin
                bit_in_row_next = '0;
                rows_done_next  = rows_inc;
                row_y_next      = row_y + COORD_BITS'(cfg.dot_vgap) + 1'b1;
                if (rows_inc >= {1'b0, cfg.glyph_rows}) begin
                  done       = 1'b1;
                  phase_next = PH_HEADER;
                end
              end else begin
                bit_in_row_next = bit_sum[8:0];
              end
            end
          end
          default: ;
        endcase
        push = done || (cmd_mask != '0);
      end
    end
  end

  assign push_cmd.mask   = cmd_mask;
  assign push_cmd.d0     = bit_in_row[7:0] - left_skip;
  assign push_cmd.cell_x = cell_x;
  assign push_cmd.row_y  = row_y;
  assign push_cmd.width  = glyph_width;
  assign push_cmd.done   = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      glyph_width <= '0;
      left_skip   <= '0;
      cell_x      <= '0;
      row_y       <= '0;
      rows_done   <= '0;
      bit_in_row  <= '0;
    end else begin
      phase       <= phase_next;
      glyph_width <= glyph_width_next;
      left_skip   <= left_skip_next;
      cell_x      <= cell_x_next;
      row_y       <= row_y_next;
      rows_done   <= rows_done_next;
      bit_in_row  <= bit_in_row_next;
    end
  end
endmodule

@@ src/bgsr_queue.sv @@
// ----------------------------------------------------------------------------
// bgsr_queue: command queue
// Small FIFO between the parser and the span emitter.
// ----------------------------------------------------------------------------
module bgsr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bgsr_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output bgsr_pkg::cmd_t head
);
  import bgsr_pkg::*;

  cmd_t          mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_AW:0]   count;

  assign full  = (count == (Q_AW+1)'(Q_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

@@ src/bgsr_back.sv @@
// ----------------------------------------------------------------------------
// bgsr_back: span emitter
// Takes commands from the queue and gives one span per set dot, then the
// glyph-done word at glyph end, one word per cycle while the output advances.
// ----------------------------------------------------------------------------
module bgsr_back (
  input  logic           clk,
  input  logic           rst,
  input  bgsr_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  bgsr_pkg::cmd_t head,
  output logic           pop,
  bgsr_out_if.source     result
);
  import bgsr_pkg::*;

  cmd_t                  cur;
  logic                  cur_valid;
  logic                  adv;
  logic                  cur_final;
  logic [2:0]            k_sel;
  logic [7:0]            mask_after;
  logic [5:0]            xd;
  logic [7:0]            dot_j;
  logic [13:0]           dot_off;
  logic [COORD_BITS-1:0] span_x;
  logic [COORD_BITS-1:0] span_r;
  logic [13:0]           width_off;
  logic [8:0]            gap_off;
  logic [COORD_BITS-1:0] adv_x;

  assign adv = !result.valid || result.ready;

  // lowest pending dot (earliest bit from the MSB)
  always_comb begin
    k_sel = '0;
    for (int k = 7; k >= 0; k--) begin
      if (cur.mask[k]) begin
        k_sel = 3'(k);
      end
    end
  end

  always_comb begin
    mask_after        = cur.mask;
    mask_after[k_sel] = 1'b0;
  end

  assign cur_final = (cur.mask == '0) || (mask_after == '0 && !cur.done);
  assign pop       = !q_empty && (!cur_valid || (adv && cur_final));

  // span and advance arithmetic
  assign xd        = {1'b0, cfg.dot_width} + {2'b0, cfg.dot_hgap};
  assign dot_j     = cur.d0 + {5'd0, k_sel};
  assign dot_off   = dot_j * xd;
  assign span_x    = cur.cell_x + COORD_BITS'(dot_off);
  assign span_r    = span_x + COORD_BITS'(cfg.dot_width) - 1'b1;
  assign width_off = cur.width * xd;
  assign gap_off   = cfg.char_gap * cfg.dot_width;
  assign adv_x     = cur.cell_x + COORD_BITS'(width_off) + COORD_BITS'(gap_off);

  // current command
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (adv && cur_valid && cur_final) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end else if (adv && cur_valid) begin
      cur.mask <= mask_after;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && cur_valid) begin
      if (cur.mask != '0) begin
        result.kind       <= KIND_SPAN;
        result.span_left  <= span_x;
        result.span_right <= span_r;
        result.span_y     <= cur.row_y;
        result.span_color <= cfg.ink_color;
        result.advance_x  <= '0;
        result.last       <= (mask_after == '0) && !cur.done;
      end else begin
        result.kind       <= KIND_DONE;
        result.span_left  <= '0;
        result.span_right <= '0;
        result.span_y     <= '0;
        result.span_color <= '0;
        result.advance_x  <= adv_x;
        result.last       <= 1'b1;
      end
    end
  end
endmodule

@@ src/bitmap_glyph_span_rasterizer.sv @@
// ----------------------------------------------------------------------------
// bitmap_glyph_span_rasterizer: bitmap font glyph to span converter
// Parses glyph bytes and emits horizontal spans plus a glyph-done word.
// ----------------------------------------------------------------------------
// Usage:
//   glyph  : input words; a word with first_byte set is the width header and
//            carries the cell origin, the next word is the left margin, then
//            packed row bytes MSB first.
//   result : output words; kind 0 is a span, kind 1 ends the glyph with the
//            next x position. last marks the final word caused by one byte.
//   APB    : six registers at byte addresses 0..20, written while idle.
// Path: an accepted byte is written to the queue at the accepting edge, then
//   taken into the emitter's current command, then into the output register.
// Throughput: one input word per cycle while the 4-entry command queue has
//   room; the emitter gives one result per cycle while the output advances,
//   holding each byte until all its results (up to 9 with glyph done) are out.
// Stall: when result.ready is low the output register holds its word, the
//   emitter and then the queue fill, and glyph.ready drops when it is full.
// Reset: synchronous; parser waits for a header, queue and output empty,
//   registers take their default values.
// ----------------------------------------------------------------------------
module bitmap_glyph_span_rasterizer (
  input  logic                           clk,
  input  logic                           rst,
  bgsr_in_if.sink                        glyph,
  bgsr_out_if.source                     result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bgsr_pkg::ADDR_BITS-1:0] paddr,
  input  logic [bgsr_pkg::DATA_BITS-1:0] pwdata,
  output logic [bgsr_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready
);
  import bgsr_pkg::*;

  cfg_t cfg;
  logic push, q_full, q_empty, pop;
  cmd_t push_cmd, head;

  bgsr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bgsr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .glyph    (glyph),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  bgsr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  bgsr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .result  (result)
  );
endmodule

@@ tb/sv/glyph_span_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_span_checker: result predictor and comparator
// Watches the register port and the glyph channel, works out the span and
// glyph-done words each accepted glyph word must cause, and compares every
// accepted result word in order against them.
// ----------------------------------------------------------------------------
module glyph_span_checker (
  input  logic                           clk,
  input  logic                           rst,
  bgsr_in_if                             glyph,
  bgsr_out_if                            result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [bgsr_pkg::ADDR_BITS-1:0] paddr,
  input  logic [bgsr_pkg::DATA_BITS-1:0] pwdata,
  output int                             mismatches,
  output int                             awaited,
  output int                             spans_seen,
  output int                             dones_seen
);
  import bgsr_pkg::*;

  localparam int MAX_ROWS = 64;

  typedef struct {
    logic        kind;
    logic [15:0] left;
    logic [15:0] right;
    logic [15:0] y;
    logic [31:0] color;
    logic [15:0] adv;
    logic        last;
  } raster_word_t;

  // predicted words not yet seen on the result channel
  raster_word_t awaited_words[$];

  // register copy and parser state
  cfg_t        cfg;
  logic [1:0]  parse_phase;
  logic [7:0]  glyph_width;
  logic [7:0]  left_skip;
  logic [15:0] cell_x;
  logic [15:0] row_y;
  int          rows_done;
  int          bit_in_row;

  int fail_count = 0;
  int span_count = 0;
  int done_count = 0;

  // glyph-done word: next character's x, then back to waiting for a header
  task automatic close_glyph();
    raster_word_t w;
    int           pitch;
    pitch   = int'(cfg.dot_width) + int'(cfg.dot_hgap);
    w.kind  = KIND_DONE;
    w.left  = '0;
    w.right = '0;
    w.y     = '0;
    w.color = '0;
    w.adv   = cell_x + 16'(int'(glyph_width) * pitch +
                           int'(cfg.char_gap) * int'(cfg.dot_width));
    w.last  = 1'b0;
    awaited_words.push_back(w);
    parse_phase = PH_HEADER;
  endtask

  // works out the words one glyph word causes and queues them
  task automatic rasterise_byte(input logic [7:0] b, input logic hdr,
                                input logic [15:0] ox, input logic [15:0] oy);
    raster_word_t w;
    int           used;
    int           row_len;
    int           pitch;
    int           pos;
    int           rows_eff;
    int           base;
    base     = awaited_words.size();
    rows_eff = (int'(cfg.glyph_rows) > MAX_ROWS) ? MAX_ROWS : int'(cfg.glyph_rows);
    pitch    = int'(cfg.dot_width) + int'(cfg.dot_hgap);
    if (hdr) begin
      // a header always starts over, even mid-glyph
      glyph_width = b;
      cell_x      = ox;
      row_y       = oy;
      rows_done   = 0;
      bit_in_row  = 0;
      parse_phase = PH_MARGIN;
    end else if (parse_phase == PH_MARGIN) begin
      left_skip   = b;
      bit_in_row  = 0;
      rows_done   = 0;
      parse_phase = PH_ROWS;
      if (rows_eff == 0 || int'(left_skip) + int'(glyph_width) == 0) close_glyph();
    end else if (parse_phase == PH_ROWS) begin
      used    = int'(left_skip) + int'(glyph_width);
      row_len = (used + 7) / 8 * 8;
      if (rows_done >= rows_eff || used == 0) begin
        close_glyph();
      end else begin
        // MSB first; margin bits are skipped, padding bits ignored
        for (int k = 0; k < 8; k++) begin
          pos = bit_in_row + k;
          if (pos >= int'(left_skip) && pos < used && b[7-k]) begin
            w.kind  = KIND_SPAN;
            w.left  = cell_x + 16'((pos - int'(left_skip)) * pitch);
            w.right = w.left + 16'(cfg.dot_width) - 16'd1;
            w.y     = row_y;
            w.color = cfg.ink_color;
            w.adv   = '0;
            w.last  = 1'b0;
            awaited_words.push_back(w);
          end
        end
        bit_in_row += 8;
        if (bit_in_row >= row_len) begin
          bit_in_row = 0;
          rows_done++;
          row_y = row_y + 16'(1 + int'(cfg.dot_vgap));
          if (rows_done >= rows_eff) close_glyph();
        end
      end
    end
    // header and ignored bytes add nothing
    if (awaited_words.size() > base) awaited_words[awaited_words.size()-1].last = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    raster_word_t w;
    if (rst) begin
      cfg.dot_width  = 5'd1;
      cfg.dot_hgap   = 4'd0;
      cfg.dot_vgap   = 4'd0;
      cfg.glyph_rows = 6'd8;
      cfg.char_gap   = 4'd1;
      cfg.ink_color  = 32'hFFFF_FFFF;
      parse_phase    = PH_HEADER;
      glyph_width    = '0;
      left_skip      = '0;
      cell_x         = '0;
      row_y          = '0;
      rows_done      = 0;
      bit_in_row     = 0;
      awaited_words.delete();
    end else begin
      // register writes land at the access cycle
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_DOT_WIDTH:  cfg.dot_width  = pwdata[4:0];
          REG_DOT_HGAP:   cfg.dot_hgap   = pwdata[3:0];
          REG_DOT_VGAP:   cfg.dot_vgap   = pwdata[3:0];
          REG_GLYPH_ROWS: cfg.glyph_rows = pwdata[5:0];
          REG_CHAR_GAP:   cfg.char_gap   = pwdata[3:0];
          REG_INK_COLOR:  cfg.ink_color  = pwdata;
          default: ;
        endcase
      end

      if (glyph.valid && glyph.ready)
        rasterise_byte(glyph.glyph_byte, glyph.first_byte, glyph.origin_x, glyph.origin_y);

      // compare the accepted result word with the oldest prediction
      if (result.valid && result.ready) begin
        if (result.kind === KIND_DONE) done_count++;
        else span_count++;
        if (awaited_words.size() == 0) begin
          $display({"%0t: unexpected result word: expected none, actual kind %b ",
                    "left %h right %h y %h colour %h adv %h last %b"},
                   $time, result.kind, result.span_left, result.span_right, result.span_y,
                   result.span_color, result.advance_x, result.last);
          fail_count++;
        end else begin
          w = awaited_words.pop_front();
          check_field("kind", {31'd0, w.kind}, {31'd0, result.kind});
          check_field("span_left", {16'd0, w.left}, {16'd0, result.span_left});
          check_field("span_right", {16'd0, w.right}, {16'd0, result.span_right});
          check_field("span_y", {16'd0, w.y}, {16'd0, result.span_y});
          check_field("span_color", w.color, result.span_color);
          check_field("advance_x", {16'd0, w.adv}, {16'd0, result.advance_x});
          check_field("last", {31'd0, w.last}, {31'd0, result.last});
        end
      end
    end
    mismatches <= fail_count;
    awaited    <= awaited_words.size();
    spans_seen <= span_count;
    dones_seen <= done_count;
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: glyph span rasteriser regression
// Drives glyph words and register writes, stalls both channels at random
// and reports the verdict from the checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;
  import bgsr_pkg::*;

  localparam int RANDOM_WORDS = 350;
  localparam int PHASE_WORDS  = 45;
  localparam int DRAIN_CYCLES = 12;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  bgsr_in_if  glyph_ch ();
  bgsr_out_if result_ch ();

  int mismatches;
  int awaited;
  int spans_seen;
  int dones_seen;

  // stimulus bookkeeping
  int src_max     = 6;
  int sink_max    = 6;
  int stim_rows   = 8;
  int words_sent  = 0;
  int noise_words = 0;
  int glyphs_sent = 0;
  int settings    = 1;

  bitmap_glyph_span_rasterizer DUT (
    .clk     (clk),
    .rst     (rst),
    .glyph   (glyph_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  glyph_span_checker span_check (
    .clk        (clk),
    .rst        (rst),
    .glyph      (glyph_ch),
    .result     (result_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .awaited    (awaited),
    .spans_seen (spans_seen),
    .dones_seen (dones_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("bitmap_glyph_span_rasterizer regression: fail");
    $finish;
  end

  // result side: random stall after each accepted word
  initial begin
    int hold;
    result_ch.ready = 1'b1;
    forever begin
      @(posedge clk);
      if (result_ch.valid && result_ch.ready) begin
        hold = $urandom_range(0, sink_max);
        if (hold != 0) begin
          @(negedge clk) result_ch.ready <= 1'b0;
          repeat (hold) @(negedge clk);
          result_ch.ready <= 1'b1;
        end
      end
    end
  end

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_dots();
    case ($urandom_range(0, 5))
      0:       return 8'hFF;
      1:       return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one glyph word, after a random gap
  task automatic send_word(input logic [7:0] b, input logic hdr,
                           input logic [15:0] ox, input logic [15:0] oy);
    int gap;
    gap = $urandom_range(0, src_max);
    @(negedge clk);
    if (gap != 0) begin
      glyph_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    glyph_ch.glyph_byte <= b;
    glyph_ch.first_byte <= hdr;
    glyph_ch.origin_x   <= ox;
    glyph_ch.origin_y   <= oy;
    glyph_ch.valid      <= 1'b1;
    do @(posedge clk); while (!glyph_ch.ready);
    words_sent++;
  endtask

  // hold off the sender until every predicted word has come out
  task automatic drain_results();
    @(negedge clk);
    glyph_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_settings(input int dw, input int hg, input int vg, input int rows,
                                input int cg, input logic [31:0] ink);
    drain_results();
    write_reg(REG_DOT_WIDTH, 32'(dw));
    write_reg(REG_DOT_HGAP, 32'(hg));
    write_reg(REG_DOT_VGAP, 32'(vg));
    write_reg(REG_GLYPH_ROWS, 32'(rows));
    write_reg(REG_CHAR_GAP, 32'(cg));
    write_reg(REG_INK_COLOR, ink);
    stim_rows = rows;
    settings++;
  endtask

  // header, margin, then rows of random dots; a cut glyph stops early
  task automatic send_glyph(input int width, input int margin, input bit cut);
    int row_bytes;
    int total;
    int keep;
    row_bytes = (width + margin + 7) / 8;
    total     = (stim_rows == 0 || width + margin == 0) ? 0 : stim_rows * row_bytes;
    keep      = (cut && total > 0) ? $urandom_range(0, total - 1) : total;
    send_word(8'(width), 1'b1, rand_coord(), rand_coord());
    send_word(8'(margin), 1'b0, rand_coord(), rand_coord());
    for (int i = 0; i < keep; i++)
      send_word(rand_dots(), 1'b0, rand_coord(), rand_coord());
    glyphs_sent++;
  endtask

  task automatic run_random_phases();
    int phase_no;
    int rand_start;
    int phase_start;
    int pick;
    int width;
    int margin;
    phase_no   = 0;
    rand_start = words_sent - noise_words;
    while (words_sent - noise_words - rand_start < RANDOM_WORDS) begin
      case (phase_no)
        0: apply_settings(0, 0, 0, 0, 0, 32'h0000_0000);
        1: apply_settings(16, 15, 15, 63, 15, 32'hFFFF_FFFF);
        2: apply_settings(31, 7, 15, 1, 15, 32'hA5A5_5A5A);
        default:
          apply_settings(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(1, 16),
                         $urandom_range(0, 15), $urandom_range(0, 15),
                         ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10),
                         $urandom_range(0, 15), $urandom);
      endcase
      // some phases run without any idling on one side or both
      src_max     = (phase_no % 3 == 1) ? 0 : 6;
      sink_max    = (phase_no % 4 == 2) ? 0 : 6;
      phase_start = words_sent - noise_words;
      // widest glyph the header and margin allow, single row
      if (phase_no == 2) send_glyph(255, 255, 1'b0);
      while (words_sent - noise_words - phase_start < PHASE_WORDS &&
             words_sent - noise_words - rand_start < RANDOM_WORDS) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          // stray data word, ignored or taken as row data after a cut glyph
          send_word(rand_dots(), 1'b0, rand_coord(), rand_coord());
          noise_words++;
        end else begin
          if (stim_rows > 16) begin
            width  = $urandom_range(0, 8);
            margin = 0;
          end else if (pick < 8 && stim_rows <= 2) begin
            width  = $urandom_range(100, 255);
            margin = $urandom_range(0, 255);
          end else if (pick < 65) begin
            width  = $urandom_range(1, 8);
            margin = $urandom_range(0, 4);
          end else begin
            width  = $urandom_range(0, 20);
            margin = $urandom_range(0, 15);
          end
          send_glyph(width, margin, $urandom_range(0, 9) == 0);
        end
      end
      phase_no++;
    end
  endtask

  initial begin
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    glyph_ch.valid      = 1'b0;
    glyph_ch.glyph_byte = '0;
    glyph_ch.first_byte = 1'b0;
    glyph_ch.origin_x   = '0;
    glyph_ch.origin_y   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // data word with no header yet: ignored
    send_word(8'hA5, 1'b0, 16'h0000, 16'h0000);
    // glyph cut short by a new header after one row
    send_word(8'd5, 1'b1, 16'h7FFF, 16'h8000);
    send_word(8'd3, 1'b0, 16'h0000, 16'h0000);
    send_word(8'hFF, 1'b0, 16'h0000, 16'h0000);
    // full eight-row glyph, x and y wrapping past the top of the range
    send_word(8'd8, 1'b1, 16'h7FFC, 16'h7FFF);
    send_word(8'd0, 1'b0, 16'hFFFF, 16'hFFFF);
    send_word(8'hFF, 1'b0, 16'h0000, 16'h0000);
    send_word(8'h00, 1'b0, 16'h0000, 16'h0000);
    send_word(8'h80, 1'b0, 16'h0000, 16'h0000);
    send_word(8'h01, 1'b0, 16'h0000, 16'h0000);
    send_word(8'hAA, 1'b0, 16'h0000, 16'h0000);
    send_word(8'h55, 1'b0, 16'h0000, 16'h0000);
    send_word(8'hFF, 1'b0, 16'h0000, 16'h0000);
    send_word(8'h81, 1'b0, 16'h0000, 16'h0000);
    // empty glyph: margin word itself ends it
    send_word(8'd0, 1'b1, 16'h1234, 16'h4321);
    send_word(8'd0, 1'b0, 16'h0000, 16'h0000);
    // row count lowered mid-glyph: next row word only ends the glyph
    send_word(8'd8, 1'b1, 16'h0100, 16'hFF00);
    send_word(8'd0, 1'b0, 16'h0000, 16'h0000);
    send_word(8'hC3, 1'b0, 16'h0000, 16'h0000);
    drain_results();
    write_reg(REG_GLYPH_ROWS, 32'd1);
    stim_rows = 1;
    send_word(8'hFF, 1'b0, 16'h0000, 16'h0000);
    send_word(8'h5A, 1'b0, 16'hFFFF, 16'h0000);

    run_random_phases();

    drain_results();
    $display("sent %0d glyph words (%0d glyphs, %0d stray) across %0d register settings",
             words_sent, glyphs_sent, noise_words, settings);
    $display("compared %0d span words and %0d glyph-done words, %0d mismatches",
             spans_seen, dones_seen, mismatches);
    if (mismatches == 0 && awaited == 0) begin
      $display("bitmap_glyph_span_rasterizer regression: pass");
    end else begin
      $display("bitmap_glyph_span_rasterizer regression: fail");
    end
    $finish;
  end

endmodule
